[rtl/assert_macros.svh]
// Assertion helpers, included by hjc_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled in reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/hjc_pkg.sv]
package hjc_pkg;

    localparam logic [15:0] SYL_BASE       = 16'hAC00;
    localparam logic [15:0] SYL_INIT_STEP  = 16'h024C;
    localparam logic [15:0] SYL_MED_STEP   = 16'h001C;
    localparam logic [15:0] VOWEL_FIRST    = 16'h314F;
    localparam int          NUM_INITIALS   = 19;
    localparam int          NUM_FINALS     = 27;
    localparam int          QUEUE_DEPTH    = 2;

    localparam logic [1:0] OP_COMMIT  = 2'd0;
    localparam logic [1:0] OP_PREVIEW = 2'd1;
    localparam logic [1:0] OP_BACK    = 2'd2;

    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_APPEND  = 2'd1;
    localparam logic [1:0] ACT_REPLACE = 2'd2;
    localparam logic [1:0] ACT_DELETE  = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] key_char;
        logic        text_empty;
        logic        has_room;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] char_code;
        logic        last;
    } out_item_t;

    // Work handed from front to back: one or two results per key.
    typedef struct packed {
        out_item_t first;
        out_item_t second;
        logic      two;
    } work_t;

    function automatic logic [15:0] syl(input logic [4:0] i, input logic [4:0] m,
                                        input logic [4:0] f);
        logic [15:0] s;
        s = SYL_BASE + 16'(i) * SYL_INIT_STEP + 16'(m) * SYL_MED_STEP + 16'(f);
        return s;
    endfunction

    function automatic logic [15:0] initial_code(input logic [4:0] idx);
        logic [15:0] c;
        case (idx)
            5'd0: c = 16'h3131;  5'd1: c = 16'h3132;  5'd2: c = 16'h3134;
            5'd3: c = 16'h3137;  5'd4: c = 16'h3138;  5'd5: c = 16'h3139;
            5'd6: c = 16'h3141;  5'd7: c = 16'h3142;  5'd8: c = 16'h3143;
            5'd9: c = 16'h3145;  5'd10: c = 16'h3146; 5'd11: c = 16'h3147;
            5'd12: c = 16'h3148; 5'd13: c = 16'h3149; 5'd14: c = 16'h314A;
            5'd15: c = 16'h314B; 5'd16: c = 16'h314C; 5'd17: c = 16'h314D;
            5'd18: c = 16'h314E;
            default: c = 16'h0000;
        endcase
        return c;
    endfunction

    function automatic logic [15:0] final_code(input logic [4:0] idx);
        logic [15:0] c;
        case (idx)
            5'd0: c = 16'h3131;  5'd1: c = 16'h3132;  5'd2: c = 16'h3133;
            5'd3: c = 16'h3134;  5'd4: c = 16'h3135;  5'd5: c = 16'h3136;
            5'd6: c = 16'h3137;  5'd7: c = 16'h3139;  5'd8: c = 16'h313A;
            5'd9: c = 16'h313B;  5'd10: c = 16'h313C; 5'd11: c = 16'h313D;
            5'd12: c = 16'h313E; 5'd13: c = 16'h313F; 5'd14: c = 16'h3140;
            5'd15: c = 16'h3141; 5'd16: c = 16'h3142; 5'd17: c = 16'h3144;
            5'd18: c = 16'h3145; 5'd19: c = 16'h3146; 5'd20: c = 16'h3147;
            5'd21: c = 16'h3148; 5'd22: c = 16'h314A; 5'd23: c = 16'h314B;
            5'd24: c = 16'h314C; 5'd25: c = 16'h314D; 5'd26: c = 16'h314E;
            default: c = 16'h0000;
        endcase
        return c;
    endfunction

    // Index lookup by code; found flag in the top bit.
    function automatic logic [5:0] find_initial(input logic [15:0] ch);
        logic [5:0] r;
        r = 6'd0;
        for (int k = NUM_INITIALS - 1; k >= 0; k--)
            if (initial_code(5'(k)) == ch) r = {1'b1, 5'(k)};
        return r;
    endfunction

    function automatic logic [5:0] find_final(input logic [15:0] ch);
        logic [5:0] r;
        r = 6'd0;
        for (int k = NUM_FINALS - 1; k >= 0; k--)
            if (final_code(5'(k)) == ch) r = {1'b1, 5'(k)};
        return r;
    endfunction

    function automatic logic [5:0] vowel_of(input logic [15:0] ch);
        logic [15:0] v;
        logic        ok;
        v  = ch - VOWEL_FIRST;
        ok = (ch >= VOWEL_FIRST) && (ch <= VOWEL_FIRST + 16'd20);
        if (v inside {[16'd9:16'd11], [16'd14:16'd16], 16'd19}) ok = 1'b0;
        return {ok, v[4:0]};
    endfunction

    // Compound vowel: typed, current -> compound.
    function automatic logic [5:0] vowel_join(input logic [4:0] v, input logic [4:0] m);
        logic [5:0] r;
        case ({v, m})
            {5'd0, 5'd8}:   r = {1'b1, 5'd9};
            {5'd1, 5'd8}:   r = {1'b1, 5'd10};
            {5'd20, 5'd8}:  r = {1'b1, 5'd11};
            {5'd4, 5'd13}:  r = {1'b1, 5'd14};
            {5'd5, 5'd13}:  r = {1'b1, 5'd15};
            {5'd20, 5'd13}: r = {1'b1, 5'd16};
            {5'd20, 5'd18}: r = {1'b1, 5'd19};
            default:        r = 6'd0;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] vowel_unjoin(input logic [4:0] m);
        logic [5:0] r;
        case (m)
            5'd9, 5'd10, 5'd11: r = {1'b1, 5'd8};
            5'd14, 5'd15, 5'd16: r = {1'b1, 5'd13};
            5'd19: r = {1'b1, 5'd18};
            default: r = 6'd0;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] final_join(input logic [4:0] f, input logic [4:0] cur);
        logic [5:0] r;
        case ({f, cur})
            {5'd18, 5'd0}:  r = {1'b1, 5'd2};
            {5'd21, 5'd3}:  r = {1'b1, 5'd4};
            {5'd26, 5'd3}:  r = {1'b1, 5'd5};
            {5'd0, 5'd7}:   r = {1'b1, 5'd8};
            {5'd15, 5'd7}:  r = {1'b1, 5'd9};
            {5'd16, 5'd7}:  r = {1'b1, 5'd10};
            {5'd18, 5'd7}:  r = {1'b1, 5'd11};
            {5'd24, 5'd7}:  r = {1'b1, 5'd12};
            {5'd25, 5'd7}:  r = {1'b1, 5'd13};
            {5'd26, 5'd7}:  r = {1'b1, 5'd14};
            {5'd18, 5'd16}: r = {1'b1, 5'd17};
            default:        r = 6'd0;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] final_unjoin(input logic [4:0] f);
        logic [5:0] r;
        case (f)
            5'd2: r = {1'b1, 5'd0};
            5'd4, 5'd5: r = {1'b1, 5'd3};
            5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14: r = {1'b1, 5'd7};
            5'd17: r = {1'b1, 5'd16};
            default: r = 6'd0;
        endcase
        return r;
    endfunction

    // Split of a compound final: {found, kept final (+1), next initial}.
    function automatic logic [10:0] final_split(input logic [4:0] f);
        logic [10:0] r;
        case (f)
            5'd2:  r = {1'b1, 5'd1, 5'd9};
            5'd4:  r = {1'b1, 5'd4, 5'd12};
            5'd5:  r = {1'b1, 5'd4, 5'd18};
            5'd8:  r = {1'b1, 5'd8, 5'd0};
            5'd9:  r = {1'b1, 5'd8, 5'd6};
            5'd10: r = {1'b1, 5'd8, 5'd7};
            5'd11: r = {1'b1, 5'd8, 5'd9};
            5'd12: r = {1'b1, 5'd8, 5'd16};
            5'd13: r = {1'b1, 5'd8, 5'd17};
            5'd14: r = {1'b1, 5'd8, 5'd18};
            5'd17: r = {1'b1, 5'd17, 5'd9};
            default: r = 11'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/hangul_jamo_composer_unit.sv]
// A key's results are registered in the work queue before they are offered.
// One key per cycle while the queue is not full; a key with two results
// holds the output for both, and the two-entry work queue absorbs this.
// Reset: rst_n clears level and jamo indices to zero and empties the queue.
module hangul_jamo_composer_unit
    import hjc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic  work_valid, work_ready;
    work_t work;

    hjc_front u_front (
        .clk(clk), .rst_n(rst_n), .valid(in_valid), .ready(in_ready), .item(in_data),
        .work_valid(work_valid), .work_ready(work_ready), .work(work)
    );

    hjc_back u_back (
        .clk(clk), .rst_n(rst_n), .work_valid(work_valid), .work_ready(work_ready),
        .work(work), .valid(out_valid), .ready(out_ready), .item(out_data)
    );

endmodule

[rtl/hjc_front.sv]
module hjc_front
    import hjc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     valid,
    output logic     ready,
    input  in_item_t item,
    output logic     work_valid,
    input  logic     work_ready,
    output work_t    work
);

    logic [1:0] level_reg, level_next;
    logic [4:0] ini_reg, ini_next, med_reg, med_next, fin_reg, fin_next;

    assign ready      = work_ready;
    assign work_valid = valid;

    always_comb
    begin
        logic        commit, room, l0;
        logic [5:0]  v, f, ci, vj, fj, vu, fu, cs;
        logic [10:0] sp;
        logic [15:0] ch;
        out_item_t   a, b;
        logic        two;
        logic [1:0]  nl;
        logic [4:0]  ni, nm, nf;

        ch     = item.key_char;
        room   = item.has_room;
        commit = item.opcode == OP_COMMIT;
        v      = vowel_of(ch);
        f      = find_final(ch);
        ci     = find_initial(ch);
        vj     = vowel_join(v[4:0], med_reg);
        fj     = final_join(f[4:0], fin_reg);
        vu     = vowel_unjoin(med_reg);
        fu     = final_unjoin(fin_reg);
        sp     = final_split(fin_reg);
        cs     = find_initial(final_code(fin_reg));
        a   = '{action: ACT_NONE, char_code: 16'd0, last: 1'b0};
        b   = '{action: ACT_NONE, char_code: 16'd0, last: 1'b1};
        two = 1'b0;
        nl = level_reg; ni = ini_reg; nm = med_reg; nf = fin_reg;
        // Plain append of the key, used by many branches.
        l0 = 1'b0;

        if (item.opcode == OP_COMMIT || item.opcode == OP_PREVIEW) begin
            if (item.text_empty || level_reg == 2'd0) l0 = 1'b1;
            else if (level_reg == 2'd1) begin
                if (!v[5]) l0 = 1'b1;
                else begin
                    a = '{ACT_REPLACE, syl(ini_reg, v[4:0], 5'd0), 1'b0};
                    nm = v[4:0]; nl = 2'd2;
                end
            end else if (level_reg == 2'd2) begin
                if (v[5]) begin
                    if (vj[5]) begin
                        a = '{ACT_REPLACE, syl(ini_reg, vj[4:0], 5'd0), 1'b0};
                        nm = vj[4:0];
                    end else if (room) begin
                        a = '{ACT_APPEND, ch, 1'b0};
                        nl = 2'd0;
                    end
                end else if (!f[5]) l0 = 1'b1;
                else begin
                    a = '{ACT_REPLACE, syl(ini_reg, med_reg, f[4:0] + 5'd1), 1'b0};
                    nf = f[4:0]; nl = 2'd3;
                end
            end else begin
                if (f[5]) begin
                    if (fj[5]) begin
                        a = '{ACT_REPLACE, syl(ini_reg, med_reg, fj[4:0] + 5'd1), 1'b0};
                        nf = fj[4:0];
                    end else l0 = 1'b1;
                end else if (!v[5]) l0 = 1'b1;
                else if (room) begin
                    if (sp[10]) begin
                        a = '{ACT_REPLACE, syl(ini_reg, med_reg, sp[9:5]), 1'b0};
                        b = '{ACT_APPEND, syl(sp[4:0], v[4:0], 5'd0), 1'b1};
                        two = 1'b1;
                        ni = sp[4:0]; nm = v[4:0]; nl = 2'd2;
                    end else if (cs[5]) begin
                        a = '{ACT_REPLACE, syl(ini_reg, med_reg, 5'd0), 1'b0};
                        b = '{ACT_APPEND, syl(cs[4:0], v[4:0], 5'd0), 1'b1};
                        two = 1'b1;
                        ni = cs[4:0]; nm = v[4:0]; nl = 2'd2;
                    end else begin
                        a = '{ACT_APPEND, ch, 1'b0};
                        nl = 2'd0;
                    end
                end
            end
            if (l0 && room) begin
                a = '{ACT_APPEND, ch, 1'b0};
                if (ci[5]) begin
                    ni = ci[4:0]; nl = 2'd1;
                end else nl = 2'd0;
            end
            if (!commit) begin
                nl = level_reg; ni = ini_reg; nm = med_reg; nf = fin_reg;
            end
        end else if (item.opcode == OP_BACK) begin
            if (!item.text_empty) begin
                case (level_reg)
                    2'd0, 2'd1: begin
                        nl = 2'd0;
                        a = '{ACT_DELETE, 16'd0, 1'b0};
                    end
                    2'd2: begin
                        if (vu[5]) begin
                            nm = vu[4:0];
                            a = '{ACT_REPLACE, syl(ini_reg, vu[4:0], 5'd0), 1'b0};
                        end else begin
                            nl = 2'd1;
                            a = '{ACT_REPLACE, initial_code(ini_reg), 1'b0};
                        end
                    end
                    default: begin
                        if (fu[5]) begin
                            nf = fu[4:0];
                            a = '{ACT_REPLACE, syl(ini_reg, med_reg, fu[4:0] + 5'd1), 1'b0};
                        end else begin
                            nl = 2'd2;
                            a = '{ACT_REPLACE, syl(ini_reg, med_reg, 5'd0), 1'b0};
                        end
                    end
                endcase
            end
        end
        a.last = !two;
        work = '{first: a, second: b, two: two};
        level_next = nl; ini_next = ni; med_next = nm; fin_next = nf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            level_reg <= 2'd0;
            ini_reg   <= 5'd0;
            med_reg   <= 5'd0;
            fin_reg   <= 5'd0;
        end else if (valid && ready) begin
            level_reg <= level_next;
            ini_reg   <= ini_next;
            med_reg   <= med_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

[rtl/hjc_back.sv]
`include "assert_macros.svh"

module hjc_back
    import hjc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      work_valid,
    output logic      work_ready,
    input  work_t     work,
    output logic      valid,
    input  logic      ready,
    output out_item_t item
);

    // Two-entry queue of work entries; the head is emitted one result at a time.
    work_t     q_reg [QUEUE_DEPTH];
    logic      rd_reg, rd_next, wr_reg, wr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic      sec_reg, sec_next;
    logic      push, pop, fire;
    work_t     head;

    assign head       = q_reg[rd_reg];
    assign work_ready = cnt_reg != 2'(QUEUE_DEPTH);
    assign push       = work_valid && work_ready;
    assign valid      = cnt_reg != 2'd0;
    assign item       = sec_reg ? head.second : head.first;
    assign fire       = valid && ready;
    assign pop        = fire && (sec_reg || !head.two);

    always_comb
    begin
        rd_next  = pop ? !rd_reg : rd_reg;
        wr_next  = push ? !wr_reg : wr_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
        sec_next = pop ? 1'b0 : (fire ? 1'b1 : sec_reg);
    end

    always_ff @(posedge clk)
    begin
        if (push) q_reg[wr_reg] <= work;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
            sec_reg <= 1'b0;
        end else begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
            sec_reg <= sec_next;
        end
    end

    `ASSERT_IMPL(a_cnt_max, 1'b1, cnt_reg <= 2'(QUEUE_DEPTH), "queue overflow")
    `ASSERT_IMPL(a_sec_two, sec_reg, valid && head.two, "second result without pair")
    `ASSERT_NEXT(a_pop_drop, pop && !push && cnt_reg == 2'd1, !valid, "queue not drained")

endmodule
